>>> sv/tsvg_pkg.sv
// tsvg_pkg: shared types and constants of the thick segment vertex generator
// no dependencies; imported by every module of the block

package tsvg_pkg;

    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // pi in q30 split as A*11520 + B, and 2^24/45 rounded up
    localparam logic [18:0] PI_A     = 19'd292817;
    localparam logic [12:0] PI_B     = 13'd7586;
    localparam logic [18:0] RECIP_45 = 19'd372828;

    // trig unit depth in cycles
    localparam int TRIG_LAT = 17;

    // vertex counter width, holds up to 127
    localparam int IDX_W = 7;

    typedef enum logic [1:0] {
        KIND_ENDPOINT  = 2'd0,
        KIND_CORNER    = 2'd1,
        KIND_START_CAP = 2'd2,
        KIND_END_CAP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_ENDPT  = 2'd0,
        OP_CORNER = 2'd1,
        OP_CENTRE = 2'd2,
        OP_POINT  = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [23:0]        len;
        logic signed [15:0] rot;
        logic [23:0]        w;
        logic               thick;
        logic               caps;
        logic [IDX_W-1:0]   total;
    } item_t;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [23:0]        len;
        logic [23:0]        w;
        op_t                op;
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } job_t;

    // taylor term divisors, innermost first
    function automatic logic [30:0] iter_div(input int k);
        logic [30:0] d;
        case (k)
            0:       d = 31'd72;
            1:       d = 31'd42;
            2:       d = 31'd20;
            default: d = 31'd6;
        endcase
        return d;
    endfunction

    // floor(2^33 / divisor)
    function automatic logic [30:0] iter_recip(input int k);
        logic [30:0] m;
        case (k)
            0:       m = 31'd119304647;
            1:       m = 31'd204522252;
            2:       m = 31'd429496729;
            default: m = 31'd1431655765;
        endcase
        return m;
    endfunction

endpackage

>>> sv/tsvg_front.sv
// tsvg_front: accepts segment requests, reduces rotation, counts vertices
// depends on tsvg_pkg; feeds a two-entry queue read by tsvg_back

module tsvg_front
    import tsvg_pkg::*;
#(
    parameter int CAP_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [111:0] s_data,
    input  logic [1:0]   s_flags,
    output logic         q_valid,
    output item_t        q_item,
    input  logic         q_pop
);

    localparam logic [IDX_W-1:0] CAP_TOTAL = IDX_W'(2 * CAP_STEPS + 8);

    item_t             mem [0:1];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        count_reg;
    item_t             new_item;
    logic signed [16:0] rot_wide;
    logic signed [16:0] rot_red;
    logic              push;

    always_comb
    begin
        rot_wide = 17'(signed'(s_data[87:72]));
        if (rot_wide >= 17'sd23040)
        begin
            rot_red = rot_wide - 17'sd23040;
        end
        else if (rot_wide <= -17'sd23040)
        begin
            rot_red = rot_wide + 17'sd23040;
        end
        else
        begin
            rot_red = rot_wide;
        end
        new_item.cx    = signed'(s_data[23:0]);
        new_item.cy    = signed'(s_data[47:24]);
        new_item.len   = s_data[71:48];
        new_item.rot   = rot_red[15:0];
        new_item.w     = s_data[111:88];
        new_item.thick = s_flags[0];
        new_item.caps  = s_flags[1];
        if (!s_flags[0])
        begin
            new_item.total = IDX_W'(2);
        end
        else if (s_flags[1])
        begin
            new_item.total = CAP_TOTAL;
        end
        else
        begin
            new_item.total = IDX_W'(4);
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> sv/tsvg_trig.sv
// tsvg_trig: pipelined q30 sine of an angle in 1/64 degree
// depends on tsvg_pkg; odd taylor series to x^9, one term per three stages

module tsvg_trig
    import tsvg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] angle,
    output logic signed [31:0] value
);

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
        logic [31:0] m;
        logic [30:0] q0;
        logic        neg;
    } tstage_t;

    logic signed [18:0] a_wide;
    logic [17:0]        u0;
    logic [17:0]        u1;
    logic [17:0]        r_q;
    logic [1:0]         quad;
    logic [12:0]        rr;

    logic [12:0] s1_rr_reg;
    logic        s1_neg_reg;
    logic [31:0] s2_p1_reg;
    logic [25:0] s2_p2_reg;
    logic        s2_neg_reg;
    logic [30:0] s3_x_reg;
    logic        s3_neg_reg;
    logic [36:0] s3_prod;
    logic [61:0] s4_sq;
    logic [61:0] fin_prod;
    logic [31:0] fin_s;

    tstage_t st_reg [0:12];

    // reduce into one turn, then fold into the first quadrant
    always_comb
    begin
        a_wide = 19'(angle) + 19'sd46080;
        u0     = a_wide[17:0];
        if (u0 >= 18'd69120)
        begin
            u1 = u0 - 18'd69120;
        end
        else if (u0 >= 18'd46080)
        begin
            u1 = u0 - 18'd46080;
        end
        else if (u0 >= 18'd23040)
        begin
            u1 = u0 - 18'd23040;
        end
        else
        begin
            u1 = u0;
        end
        if (u1 >= 18'd17280)
        begin
            quad = 2'd3;
            r_q  = u1 - 18'd17280;
        end
        else if (u1 >= 18'd11520)
        begin
            quad = 2'd2;
            r_q  = u1 - 18'd11520;
        end
        else if (u1 >= 18'd5760)
        begin
            quad = 2'd1;
            r_q  = u1 - 18'd5760;
        end
        else
        begin
            quad = 2'd0;
            r_q  = u1;
        end
        rr = quad[0] ? 13'(18'd5760 - r_q) : r_q[12:0];
    end

    assign s3_prod = 37'(s2_p2_reg[25:8]) * 37'(RECIP_45);
    assign s4_sq   = 62'(s3_x_reg) * 62'(s3_x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_rr_reg  <= rr;
            s1_neg_reg <= quad[1];
            s2_p1_reg  <= 32'(s1_rr_reg) * 32'(PI_A);
            s2_p2_reg  <= 26'(s1_rr_reg) * 26'(PI_B);
            s2_neg_reg <= s1_neg_reg;
            s3_x_reg   <= 31'(s2_p1_reg + 32'(s3_prod[36:24]));
            s3_neg_reg <= s2_neg_reg;
            st_reg[0].x   <= s3_x_reg;
            st_reg[0].x2  <= s4_sq[61:30];
            st_reg[0].t   <= Q30_ONE;
            st_reg[0].m   <= '0;
            st_reg[0].q0  <= '0;
            st_reg[0].neg <= s3_neg_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_term
        localparam logic [30:0] DIV = iter_div(k);
        localparam logic [30:0] REC = iter_recip(k);
        logic [62:0] pa;
        logic [62:0] pb;
        logic [31:0] qd;
        logic [31:0] rem;
        logic [30:0] q;
        tstage_t     n1;
        tstage_t     n2;
        tstage_t     n3;

        assign pa  = 63'(st_reg[3*k].x2) * 63'(st_reg[3*k].t);
        assign pb  = 63'(st_reg[3*k+1].m) * 63'(REC);
        assign qd  = 32'(33'(st_reg[3*k+2].q0) * 33'(DIV));
        assign rem = st_reg[3*k+2].m - qd;
        assign q   = st_reg[3*k+2].q0 + ((rem >= 32'(DIV)) ? 31'd1 : 31'd0);

        // product, reciprocal quotient estimate, then one correction step
        always_comb
        begin
            n1    = st_reg[3*k];
            n1.m  = pa[61:30];
            n2    = st_reg[3*k+1];
            n2.q0 = 31'(pb[62:33]);
            n3    = st_reg[3*k+2];
            n3.t  = Q30_ONE - q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[3*k+1] <= n1;
                st_reg[3*k+2] <= n2;
                st_reg[3*k+3] <= n3;
            end
        end
    end

    assign fin_prod = 62'(st_reg[12].x) * 62'(st_reg[12].t);
    assign fin_s    = (fin_prod[61:30] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : fin_prod[61:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value <= st_reg[12].neg ? -signed'(fin_s) : signed'(fin_s);
        end
    end

endmodule

>>> sv/tsvg_back.sv
// tsvg_back: vertex sequencer, trig pipeline, offset scaling and output register
// depends on tsvg_pkg and tsvg_trig; pulls items from the tsvg_front queue

module tsvg_back
    import tsvg_pkg::*;
#(
    parameter int CAP_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] out_x,
    output logic [23:0] out_y,
    output logic [5:0]  out_index,
    output kind_t       out_kind,
    output logic        out_last
);

    localparam int SW = (CAP_STEPS < 2) ? 1 : $clog2(CAP_STEPS + 1);
    localparam logic [IDX_W-1:0] SC_FIRST  = IDX_W'(5);
    localparam logic [IDX_W-1:0] EC_CENTRE = IDX_W'(CAP_STEPS + 6);
    localparam logic [IDX_W-1:0] EC_FIRST  = IDX_W'(CAP_STEPS + 7);

    logic [13:0] step_tab [0:CAP_STEPS];

    for (genvar g = 0; g <= CAP_STEPS; g++)
    begin : g_step
        assign step_tab[g] = 14'((g * HALF_TURN + CAP_STEPS / 2) / CAP_STEPS);
    end

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    item_t            item_reg;
    logic             adv;
    logic             issue;
    logic             last_issue;
    logic             load;

    job_t               job;
    logic signed [16:0] angle;
    logic signed [16:0] cos_angle;
    logic [IDX_W-1:0]   j;

    job_t                  sb_reg [0:TRIG_LAT-1];
    logic [TRIG_LAT-1:0]   sbv_reg;
    logic signed [31:0]    cos_v;
    logic signed [31:0]    sin_v;

    job_t               h_job_reg;
    logic               h_valid_reg;
    logic signed [24:0] dlx_reg;
    logic signed [24:0] dly_reg;
    logic signed [24:0] pwc_reg;
    logic signed [24:0] pws_reg;

    logic signed [26:0] sx_reg;
    logic signed [26:0] sy_reg;
    logic signed [26:0] ex_reg;
    logic signed [26:0] ey_reg;

    logic signed [26:0] cx27;
    logic signed [26:0] cy27;
    logic signed [26:0] lo_x;
    logic signed [26:0] lo_y;
    logic signed [26:0] hi_x;
    logic signed [26:0] hi_y;
    logic signed [26:0] vx;
    logic signed [26:0] vy;

    logic out_valid_reg;

    // round(mag * trig / 2^31), half away from zero
    function automatic logic signed [24:0] half_scale(input logic [23:0] mag,
                                                      input logic signed [31:0] trig);
        logic signed [56:0] p;
        logic signed [56:0] r;
        p = 57'(signed'({1'b0, mag})) * 57'(trig);
        if (p >= 0)
        begin
            r = (p + 57'sd1073741824) >>> 31;
        end
        else
        begin
            r = -((-p + 57'sd1073741824) >>> 31);
        end
        return r[24:0];
    endfunction

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] r;
        if (v > 27'sd8388607)
        begin
            r = 24'h7F_FFFF;
        end
        else if (v < -27'sd8388608)
        begin
            r = 24'h80_0000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign adv        = !out_valid_reg || out_ready;
    assign issue      = busy_reg && adv;
    assign last_issue = (idx_reg == item_reg.total - IDX_W'(1));
    assign load       = q_valid && (!busy_reg || (issue && last_issue));
    assign q_pop      = load;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (last_issue)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= q_item;
        end
    end

    // job for the current vertex
    always_comb
    begin
        job.cx   = item_reg.cx;
        job.cy   = item_reg.cy;
        job.len  = item_reg.len;
        job.w    = item_reg.w;
        job.idx  = idx_reg;
        job.last = last_issue;
        angle    = 17'(item_reg.rot);
        j        = '0;
        if (!item_reg.thick)
        begin
            job.op   = OP_ENDPT;
            job.kind = KIND_ENDPOINT;
        end
        else if (idx_reg < IDX_W'(4))
        begin
            job.op   = OP_CORNER;
            job.kind = KIND_CORNER;
        end
        else if (idx_reg == IDX_W'(4))
        begin
            job.op   = OP_CENTRE;
            job.kind = KIND_START_CAP;
        end
        else if (idx_reg < EC_CENTRE)
        begin
            job.op   = OP_POINT;
            job.kind = KIND_START_CAP;
            j        = idx_reg - SC_FIRST;
            angle    = 17'(item_reg.rot) - 17'sd5760 - 17'(step_tab[j[SW-1:0]]);
        end
        else if (idx_reg == EC_CENTRE)
        begin
            job.op   = OP_CENTRE;
            job.kind = KIND_END_CAP;
        end
        else
        begin
            job.op   = OP_POINT;
            job.kind = KIND_END_CAP;
            j        = idx_reg - EC_FIRST;
            angle    = 17'(item_reg.rot) + 17'sd5760 - 17'(step_tab[j[SW-1:0]]);
        end
    end

    assign cos_angle = angle + 17'sd5760;

    tsvg_trig u_cos
    (
        .clk   (clk),
        .en    (adv),
        .angle (cos_angle),
        .value (cos_v)
    );

    tsvg_trig u_sin
    (
        .clk   (clk),
        .en    (adv),
        .angle (angle),
        .value (sin_v)
    );

    // job sideband riding along the trig units
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= job;
            for (int k = 1; k < TRIG_LAT; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
            h_job_reg <= sb_reg[TRIG_LAT-1];
            dlx_reg   <= half_scale(sb_reg[TRIG_LAT-1].len, cos_v);
            dly_reg   <= half_scale(sb_reg[TRIG_LAT-1].len, sin_v);
            pwc_reg   <= half_scale(sb_reg[TRIG_LAT-1].w, cos_v);
            pws_reg   <= half_scale(sb_reg[TRIG_LAT-1].w, sin_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbv_reg     <= '0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sbv_reg     <= {sbv_reg[TRIG_LAT-2:0], issue};
            h_valid_reg <= sbv_reg[TRIG_LAT-1];
        end
    end

    // vertex assembly
    always_comb
    begin
        cx27 = 27'(h_job_reg.cx);
        cy27 = 27'(h_job_reg.cy);
        lo_x = cx27 - 27'(dlx_reg);
        lo_y = cy27 - 27'(dly_reg);
        hi_x = cx27 + 27'(dlx_reg);
        hi_y = cy27 + 27'(dly_reg);
        case (h_job_reg.op)
            OP_ENDPT:
            begin
                vx = h_job_reg.idx[0] ? hi_x : lo_x;
                vy = h_job_reg.idx[0] ? hi_y : lo_y;
            end
            OP_CORNER:
            begin
                vx = h_job_reg.idx[1] ? hi_x : lo_x;
                vy = h_job_reg.idx[1] ? hi_y : lo_y;
                if (h_job_reg.idx[0])
                begin
                    vx = vx - 27'(pws_reg);
                    vy = vy + 27'(pwc_reg);
                end
                else
                begin
                    vx = vx + 27'(pws_reg);
                    vy = vy - 27'(pwc_reg);
                end
            end
            OP_CENTRE:
            begin
                vx = (h_job_reg.kind == KIND_START_CAP) ? sx_reg : ex_reg;
                vy = (h_job_reg.kind == KIND_START_CAP) ? sy_reg : ey_reg;
            end
            default:
            begin
                vx = ((h_job_reg.kind == KIND_START_CAP) ? sx_reg : ex_reg) + 27'(pwc_reg);
                vy = ((h_job_reg.kind == KIND_START_CAP) ? sy_reg : ey_reg) + 27'(pws_reg);
            end
        endcase
    end

    // endpoints kept for the cap fans of the same segment
    always_ff @(posedge clk)
    begin
        if (adv && h_valid_reg && (h_job_reg.op == OP_CORNER))
        begin
            sx_reg <= lo_x;
            sy_reg <= lo_y;
            ex_reg <= hi_x;
            ey_reg <= hi_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x     <= sat24(vx);
            out_y     <= sat24(vy);
            out_index <= h_job_reg.idx[5:0];
            out_kind  <= h_job_reg.kind;
            out_last  <= h_job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= h_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/thick_segment_vertex_generator_unit.sv
// thick_segment_vertex_generator_unit: throughput one vertex per cycle while the receiver is ready
// and requests wait in the queue; a segment has 2, 4 or 2*CAP_STEPS+8 vertices,
// the vertex sequencer issuing one trig job per vertex into the sine units
// a two-entry request queue lets a new segment enter while vertices still drain
// reset: rst_n asynchronous, clears queue, sequencer and valid flags; no clearing pass

module thick_segment_vertex_generator_unit
    import tsvg_pkg::*;
#(
    parameter int CAP_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // centre_x[23:0] centre_y[47:24] seg_length[71:48] rotation[87:72] width[111:88]
    input  logic [111:0] s_axis_tdata,
    // thick[0] round_caps[1]
    input  logic [1:0]   s_axis_tuser,
    // vertex channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_x[23:0] vertex_y[47:24] vertex_index[53:48] zero pad[55:54]
    output logic [55:0]  m_axis_tdata,
    // vertex_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    // front to back queue
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    logic [23:0] vertex_x;
    logic [23:0] vertex_y;
    logic [5:0]  vertex_index;
    kind_t       vertex_kind;

    // front: unpacks, folds rotation, counts vertices, queues requests
    tsvg_front #(
        .CAP_STEPS (CAP_STEPS)
    ) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_flags (s_axis_tuser),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // back: one job per vertex through sine and cosine pipelines, then offsets
    tsvg_back #(
        .CAP_STEPS (CAP_STEPS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (vertex_x),
        .out_y     (vertex_y),
        .out_index (vertex_index),
        .out_kind  (vertex_kind),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, vertex_index, vertex_y, vertex_x};
    assign m_axis_tuser = vertex_kind;

    // strip corners only ever occupy the first four places
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_CORNER)) |-> (m_axis_tdata[53:50] == 4'd0))
        else $error("corner vertex with index beyond four");

    // a thin segment ends on its second endpoint
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ENDPOINT) && m_axis_tlast)
        |-> (m_axis_tdata[53:48] == 6'd1))
        else $error("endpoint pair closed at wrong index");

    // a segment of end points never marks its first vertex last
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_ENDPOINT) && (m_axis_tdata[53:48] == 6'd0))
        |-> !m_axis_tlast)
        else $error("first endpoint flagged last");

endmodule

>>> dv/thick_segment_vertex_generator_unit_checker.sv
// vertex predictor and scoreboard for thick_segment_vertex_generator_unit
// depends on tsvg_pkg for the vertex kind codes and turn constants

`timescale 1ns / 100ps

module thick_segment_vertex_generator_unit_checker
    import tsvg_pkg::*;
#(
    parameter int CAP_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_vertices
);

    localparam longint Q30 = 64'sd1073741824;
    localparam longint PI_Q30_L = 64'sd3373259426;

    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [5:0]         vidx;
        kind_t              vkind;
        logic               vlast;
    } vertex_t;

    vertex_t vertex_queue[$];
    int      seg_total;
    int      seg_count;

    function automatic longint q30_mul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // sine of r/64 degree inside the first quadrant, q30
    function automatic longint quadrant_sine(int r);
        longint x, x2, t, s;
        x  = (longint'(r) * PI_Q30_L) / HALF_TURN;
        x2 = q30_mul(x, x);
        t  = Q30;
        t  = Q30 - q30_mul(x2, t) / 72;
        t  = Q30 - q30_mul(x2, t) / 42;
        t  = Q30 - q30_mul(x2, t) / 20;
        t  = Q30 - q30_mul(x2, t) / 6;
        s  = q30_mul(x, t);
        if (s < 0) s = 0;
        if (s > Q30) s = Q30;
        return s;
    endfunction

    function automatic longint angle_sine(int a);
        int u, q, r;
        u = a % FULL_TURN;
        if (u < 0) u += FULL_TURN;
        q = u / QUARTER_TURN;
        r = u % QUARTER_TURN;
        case (q)
            0: return quadrant_sine(r);
            1: return quadrant_sine(QUARTER_TURN - r);
            2: return -quadrant_sine(r);
            default: return -quadrant_sine(QUARTER_TURN - r);
        endcase
    endfunction

    function automatic longint angle_cosine(int a);
        return angle_sine(a + QUARTER_TURN);
    endfunction

    // round(mag * trig / 2^31), ties away from zero
    function automatic longint half_offset(longint mag, longint trig);
        longint p;
        p = mag * trig;
        if (p >= 0) return (p + (64'sd1 <<< 30)) >>> 31;
        return -(((-p) + (64'sd1 <<< 30)) >>> 31);
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic void push_vertex(longint x, longint y, kind_t k);
        vertex_t v;
        v.vx    = clamp24(x);
        v.vy    = clamp24(y);
        v.vidx  = seg_count[5:0];
        v.vkind = k;
        v.vlast = (seg_count == seg_total - 1);
        vertex_queue = {vertex_queue, v};
        seg_count++;
    endfunction

    function automatic void push_cap_fan(longint cx, longint cy, int base, longint w,
                                          kind_t k);
        int step;
        push_vertex(cx, cy, k);
        for (int i = 0; i <= CAP_STEPS; i++)
        begin
            step = int'((longint'(i) * HALF_TURN + CAP_STEPS / 2) / CAP_STEPS);
            push_vertex(cx + half_offset(w, angle_cosine(base - step)),
                        cy + half_offset(w, angle_sine(base - step)), k);
        end
    endfunction

    function automatic void predict_segment(logic [111:0] d, logic [1:0] u);
        longint cx, cy, len, w, c, s, dx, dy, px, py;
        int rot;
        cx  = longint'($signed(d[23:0]));
        cy  = longint'($signed(d[47:24]));
        len = longint'(d[71:48]);
        rot = int'($signed(d[87:72])) % FULL_TURN;
        w   = longint'(d[111:88]);
        c   = angle_cosine(rot);
        s   = angle_sine(rot);
        dx  = half_offset(len, c);
        dy  = half_offset(len, s);
        seg_count = 0;
        if (!u[0])
        begin
            seg_total = 2;
            push_vertex(cx - dx, cy - dy, KIND_ENDPOINT);
            push_vertex(cx + dx, cy + dy, KIND_ENDPOINT);
            return;
        end
        seg_total = u[1] ? 4 + 2 * (CAP_STEPS + 2) : 4;
        px = half_offset(w, -s);
        py = half_offset(w, c);
        push_vertex(cx - dx - px, cy - dy - py, KIND_CORNER);
        push_vertex(cx - dx + px, cy - dy + py, KIND_CORNER);
        push_vertex(cx + dx - px, cy + dy - py, KIND_CORNER);
        push_vertex(cx + dx + px, cy + dy + py, KIND_CORNER);
        if (u[1])
        begin
            push_cap_fan(cx - dx, cy - dy, rot - QUARTER_TURN, w, KIND_START_CAP);
            push_cap_fan(cx + dx, cy + dy, rot + QUARTER_TURN, w, KIND_END_CAP);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t vertex mismatch on %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t e;
        if (!rst_n)
        begin
            fail_count       = 0;
            pending_vertices = vertex_queue.size();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (vertex_queue.size() == 0)
                    report_mismatch("unexpected vertex", 1, 0);
                else
                begin
                    e = vertex_queue.pop_front();
                    if ($signed(m_axis_tdata[23:0]) != e.vx)
                        report_mismatch("x", $signed(m_axis_tdata[23:0]), e.vx);
                    if ($signed(m_axis_tdata[47:24]) != e.vy)
                        report_mismatch("y", $signed(m_axis_tdata[47:24]), e.vy);
                    if (m_axis_tdata[53:48] != e.vidx)
                        report_mismatch("index", m_axis_tdata[53:48], e.vidx);
                    if (m_axis_tuser != e.vkind)
                        report_mismatch("kind", m_axis_tuser, e.vkind);
                    if (m_axis_tlast != e.vlast)
                        report_mismatch("last", m_axis_tlast, e.vlast);
                end
            end
            // predict after the pop so a same-cycle request cannot be consumed early
            if (s_axis_tvalid && s_axis_tready)
                predict_segment(s_axis_tdata, s_axis_tuser);
            pending_vertices = vertex_queue.size();
        end
    end

endmodule

>>> dv/thick_segment_vertex_generator_unit_test.sv
// stimulus and verdict for thick_segment_vertex_generator_unit
// depends on tsvg_pkg, the block and thick_segment_vertex_generator_unit_checker

`timescale 1ns / 100ps

module thick_segment_vertex_generator_unit_test;
    import tsvg_pkg::*;

    localparam int CAP_STEPS   = 16;
    localparam int RANDOM_SEGS = 500;
    localparam int CYCLE_LIMIT = 1000000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // centre_x, centre_y, seg_length, rotation, width from the lowest bit up
    logic [111:0] s_axis_tdata;
    // thick, round_caps
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // vertex_x, vertex_y, vertex_index, zero pad
    logic [55:0]  m_axis_tdata;
    // vertex_kind
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int  fail_count;
    int  pending_vertices;
    int  cycle_count;
    bit  hold_off;

    thick_segment_vertex_generator_unit #(.CAP_STEPS(CAP_STEPS)) uut (.*);

    thick_segment_vertex_generator_unit_checker #(.CAP_STEPS(CAP_STEPS)) vertex_checker (
        .*
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit: worst case is 40 vertices per segment plus long receiver stalls
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("thick_segment_vertex_generator_unit verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stall, long hold-off when requested
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (cycle_count % 3000 < 1000)
                m_axis_tready <= 1'b1;  // stretch with no stalls
            else
            begin
                stall = gap_length();
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // long receiver hold-off, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (cycle_count == 4000);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    // valid stays up between back-to-back requests and drops only for a gap
    task automatic send_segment(logic signed [23:0] cx, logic signed [23:0] cy,
                                logic [23:0] len, logic signed [15:0] rot,
                                logic [23:0] w, logic thick, logic caps, bit gaps);
        int idle;
        idle = gaps ? gap_length() : 0;
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w, rot, len, cy, cx};
        s_axis_tuser  <= {caps, thick};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_rotation();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'(23040 - $urandom_range(0, 46080));
        if (r == 1) return 16'($urandom_range(0, 8) * 2880 - 11520);
        return 16'($urandom);
    endfunction

    function automatic logic [23:0] random_mag();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 4096));
            1: return 24'($urandom);
            2: return 24'hFFFFFF - 24'($urandom_range(0, 3));
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each output mode, zero length, wrapped rotation
        send_segment(24'sd0, 24'sd0, 24'd2560, 16'sd0, 24'd512, 1'b0, 1'b0, 0);
        send_segment(24'sd0, 24'sd0, 24'd2560, 16'sd0, 24'd512, 1'b0, 1'b1, 0);
        send_segment(24'sd100, -24'sd100, 24'd2560, 16'sd2880, 24'd512, 1'b1, 1'b0, 0);
        send_segment(24'sd100, -24'sd100, 24'd2560, 16'sd2880, 24'd512, 1'b1, 1'b1, 0);
        send_segment(24'sd5, 24'sd7, 24'd0, 16'sd1000, 24'd1024, 1'b1, 1'b1, 0);
        send_segment(24'sd5, 24'sd7, 24'd0, -16'sd23040, 24'd1024, 1'b1, 1'b0, 0);
        send_segment(24'sd0, 24'sd0, 24'd300, 16'sd23040, 24'd300, 1'b1, 1'b1, 0);
        send_segment(24'sd0, 24'sd0, 24'd300, 16'sd32767, 24'd300, 1'b1, 1'b1, 0);
        send_segment(24'sd0, 24'sd0, 24'd300, -16'sd32768, 24'd300, 1'b1, 1'b0, 0);
        send_segment(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF, 16'sd0, 24'hFFFFFF, 1'b1, 1'b1, 0);
        send_segment(-24'sh800000, -24'sh800000, 24'hFFFFFF, 16'sd11520, 24'hFFFFFF,
                     1'b1, 1'b1, 0);
        send_segment(-24'sh800000, 24'sh7FFFFF, 24'hFFFFFF, 16'sd5760, 24'd0, 1'b0, 1'b0, 0);
        send_segment(24'sh7FFFFF, -24'sh800000, 24'd0, -16'sd5760, 24'hFFFFFF, 1'b1, 1'b1, 0);
        send_segment(24'sd0, 24'sd0, 24'd1000, 16'sd17280, 24'd0, 1'b1, 1'b1, 0);
        send_segment(24'sh555555, -24'sh2AAAAB, 24'hAAAAAA, 16'sh5555, 24'h555555,
                     1'b1, 1'b1, 0);

        // random segments; thick with caps most often as it reaches the fans
        for (int n = 0; n < RANDOM_SEGS; n++)
        begin
            send_segment(24'($urandom), 24'($urandom), random_mag(), random_rotation(),
                         random_mag(), $urandom_range(0, 3) != 0,
                         $urandom_range(0, 2) != 0, 1);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then a latency-sized settle
        @(posedge clk);
        while (pending_vertices != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("thick_segment_vertex_generator_unit verification clean");
        else
            $display("thick_segment_vertex_generator_unit verification failed");
        $finish;
    end

endmodule
